FILE: hdl/three_phase_sine_pwm_reference_top_macros.svh
// assertion macros for the three-phase sine pwm block
`ifndef THREE_PHASE_SINE_PWM_REFERENCE_TOP_MACROS_SVH
`define THREE_PHASE_SINE_PWM_REFERENCE_TOP_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define SPWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// antecedent in this cycle implies consequent in the next cycle
`define SPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hdl/spwm_pkg.sv
// shared types, constants and sine table for the three-phase sine pwm block
`default_nettype none
package spwm_pkg;

  localparam int PHASE_BITS = 16;
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int TIMER_W    = 32;
  localparam int DIV_STAGES = TIMER_W + PHASE_BITS;
  localparam int AMP_W      = 19;
  localparam int LIM_W      = 16;
  localparam int CMP_W      = 16;
  localparam int SIN_W      = 16;
  localparam int DUTY_W     = 17;
  localparam int PROD_W     = AMP_W + SIN_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [PHASE_BITS-1:0] OFFSET_120 =
    PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
  localparam logic [PHASE_BITS-1:0] OFFSET_240 =
    PHASE_BITS'(((64'd2 << PHASE_BITS) + 64'd1) / 64'd3);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AMP_R    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_S    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_T    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PER = 3'd5;

  typedef struct packed {
    logic [TIMER_W-1:0] timer_count;
    logic [TIMER_W-1:0] period_count;
  } spwm_in_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_r;
    logic [CMP_W-1:0] compare_s;
    logic [CMP_W-1:0] compare_t;
  } spwm_out_t;

  typedef logic signed [SIN_W-1:0] sine_rom_t [SINE_DEPTH];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'h4000_0000;

  // shift and subtract quotient, used only while the table is built
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // q1.15 sine from a q30 quarter-wave taylor series
  function automatic logic signed [SIN_W-1:0] sine_entry(input int k);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] dv;
    logic signed [63:0] sum;
    logic [1:0] quad;
    t    = (64'(k) << 32) >> SINE_AW;
    quad = t[31:30];
    r    = t & (ONE_Q30 - 64'd1);
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    x   = (r * HALF_PI_Q30) >> 30;
    mag = x;
    sum = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      case (n)
        1: dv = 64'd6;
        2: dv = 64'd20;
        3: dv = 64'd42;
        4: dv = 64'd72;
        5: dv = 64'd110;
        6: dv = 64'd156;
        7: dv = 64'd210;
        default: dv = 64'd1;
      endcase
      mag = (mag * x) >> 30;
      mag = (mag * x) >> 30;
      mag = div_u64(mag, dv);
      if (n % 2 == 1) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = ($unsigned(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return quad[1] ? -$signed(SIN_W'(q)) : $signed(SIN_W'(q));
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

FILE: hdl/spwm_phase_div.sv
// pipelined restoring divider giving the line phase in turns
`default_nettype none
module spwm_phase_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [spwm_pkg::TIMER_W-1:0]     timer,
  input  wire logic [spwm_pkg::TIMER_W-1:0]     period,
  output logic                                  out_valid,
  output logic [spwm_pkg::PHASE_BITS-1:0]       out_phase
);

  localparam int N = spwm_pkg::DIV_STAGES;
  localparam int T = spwm_pkg::TIMER_W;
  localparam int P = spwm_pkg::PHASE_BITS;

  logic         vld_r  [N];
  logic         zero_r [N];
  logic [T-1:0] tmr_r  [N];
  logic [T-1:0] per_r  [N];
  logic [T-1:0] rem_r  [N];
  logic [P-1:0] quo_r  [N];

  // one quotient bit per stage
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic         v_in;
    logic         z_in;
    logic [T-1:0] t_in;
    logic [T-1:0] p_in;
    logic [T-1:0] rem_in;
    logic [P-1:0] q_in;
    logic         bit_in;
    logic [T:0]   trial;
    logic [T:0]   diff;
    logic         qbit;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign z_in   = (period == '0);
      assign t_in   = timer;
      assign p_in   = period;
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = vld_r[s-1];
      assign z_in   = zero_r[s-1];
      assign t_in   = tmr_r[s-1];
      assign p_in   = per_r[s-1];
      assign rem_in = rem_r[s-1];
      assign q_in   = quo_r[s-1];
    end

    // dividend bits, then the zero bits of the turn scaling
    if (s < T) begin : g_tbit
      assign bit_in = t_in[T-1-s];
    end else begin : g_zbit
      assign bit_in = 1'b0;
    end

    assign trial = {rem_in, bit_in};
    assign diff  = trial - {1'b0, p_in};
    assign qbit  = (trial >= {1'b0, p_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[s] <= z_in;
        tmr_r[s]  <= t_in;
        per_r[s]  <= p_in;
        rem_r[s]  <= qbit ? diff[T-1:0] : trial[T-1:0];
        quo_r[s]  <= {q_in[P-2:0], qbit};
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_phase = zero_r[N-1] ? '0 : quo_r[N-1];

endmodule
`default_nettype wire

FILE: hdl/spwm_sine_rom.sv
// sine table rom with registered read
`default_nettype none
module spwm_sine_rom (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [spwm_pkg::SINE_AW-1:0]        rd_addr,
  output logic signed [spwm_pkg::SIN_W-1:0]        rd_data
);

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= spwm_pkg::SINE_ROM[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/three_phase_sine_pwm_reference_top.sv
// top level of the three-phase sine pwm compare generator
//
// usage:
//   in_*  : one beat carries the capture timer count and the line period
//   out_* : one beat carries the three pwm compare values r, s, t
//   cfg_* : register writes, index 0..5 (amplitudes r/s/t, duty high and
//           low limits, pwm half period); always ready, other indexes ignored
// pipeline: 52 register stages: 48 divider stages, one bit each, then index, rom
//   read, multiply, and clamp/saturate into the output register
// throughput: one beat per cycle while not stalled; the whole pipe moves together
// stall: while out_valid is high and out_ready low every stage holds and
//   in_ready drops; nothing is lost or repeated
// reset: synchronous, active low; clears valid bits and loads register
//   defaults (amplitudes 0, limits +32767/-32768, half period 0)
// registers should be written only while no beat is in flight
`default_nettype none
`include "three_phase_sine_pwm_reference_top_macros.svh"
module three_phase_sine_pwm_reference_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire spwm_pkg::spwm_in_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output spwm_pkg::spwm_out_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [spwm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [spwm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int P  = spwm_pkg::PHASE_BITS;
  localparam int AW = spwm_pkg::SINE_AW;

  // configuration registers
  logic [spwm_pkg::AMP_W-1:0]        amp_r_r, amp_s_r, amp_t_r;
  logic signed [spwm_pkg::LIM_W-1:0] duty_hi_r, duty_lo_r;
  logic [spwm_pkg::CMP_W-1:0]        half_per_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r_r    <= '0;
      amp_s_r    <= '0;
      amp_t_r    <= '0;
      duty_hi_r  <= 16'sd32767;
      duty_lo_r  <= -16'sd32768;
      half_per_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        spwm_pkg::REG_AMP_R:    amp_r_r    <= cfg_data[spwm_pkg::AMP_W-1:0];
        spwm_pkg::REG_AMP_S:    amp_s_r    <= cfg_data[spwm_pkg::AMP_W-1:0];
        spwm_pkg::REG_AMP_T:    amp_t_r    <= cfg_data[spwm_pkg::AMP_W-1:0];
        spwm_pkg::REG_DUTY_HI:  duty_hi_r  <= $signed(cfg_data[spwm_pkg::LIM_W-1:0]);
        spwm_pkg::REG_DUTY_LO:  duty_lo_r  <= $signed(cfg_data[spwm_pkg::LIM_W-1:0]);
        spwm_pkg::REG_HALF_PER: half_per_r <= cfg_data[spwm_pkg::CMP_W-1:0];
        default: ;
      endcase
    end
  end

  // global pipe enable: move while the output slot is free or draining
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // phase = timer / period in turns
  logic         div_valid;
  logic [P-1:0] div_phase;

  spwm_phase_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .timer     (in_data.timer_count),
    .period    (in_data.period_count),
    .out_valid (div_valid),
    .out_phase (div_phase)
  );

  // index stage: three phase offsets, wrapping, then table address
  logic          idx_valid_r;
  logic [AW-1:0] idx_r_r, idx_s_r, idx_t_r;
  logic [P-1:0]  ph_s, ph_t;

  assign ph_s = div_phase + spwm_pkg::OFFSET_240;
  assign ph_t = div_phase + spwm_pkg::OFFSET_120;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_valid_r <= 1'b0;
    end else if (en) begin
      idx_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r_r <= div_phase[P-1 -: AW];
      idx_s_r <= ph_s[P-1 -: AW];
      idx_t_r <= ph_t[P-1 -: AW];
    end
  end

  // rom stage: one table copy per phase
  logic                              rom_valid_r;
  logic signed [spwm_pkg::SIN_W-1:0] sin_r, sin_s, sin_t;

  spwm_sine_rom u_rom_r (.clk(clk), .en(en), .rd_addr(idx_r_r), .rd_data(sin_r));
  spwm_sine_rom u_rom_s (.clk(clk), .en(en), .rd_addr(idx_s_r), .rd_data(sin_s));
  spwm_sine_rom u_rom_t (.clk(clk), .en(en), .rd_addr(idx_t_r), .rd_data(sin_t));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_valid_r <= 1'b0;
    end else if (en) begin
      rom_valid_r <= idx_valid_r;
    end
  end

  // multiply stage: amplitude times sine; the floor shift by 19 follows in the clamp stage
  logic                               mul_valid_r;
  logic signed [spwm_pkg::PROD_W-1:0] prod_r_r, prod_s_r, prod_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (en) begin
      mul_valid_r <= rom_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r_r <= $signed({1'b0, amp_r_r}) * sin_r;
      prod_s_r <= $signed({1'b0, amp_s_r}) * sin_s;
      prod_t_r <= $signed({1'b0, amp_t_r}) * sin_t;
    end
  end

  // clamp to limits, add center, saturate to 0..65535
  function automatic logic [spwm_pkg::CMP_W-1:0] to_compare(
    input logic signed [spwm_pkg::PROD_W-1:0] prod,
    input logic signed [spwm_pkg::LIM_W-1:0]  hi,
    input logic signed [spwm_pkg::LIM_W-1:0]  lo,
    input logic [spwm_pkg::CMP_W-1:0]         half
  );
    logic signed [spwm_pkg::PROD_W-1:0] shifted;
    logic signed [spwm_pkg::DUTY_W-1:0] duty;
    logic signed [spwm_pkg::DUTY_W:0]   sum;
    shifted = prod >>> 19;
    duty    = shifted[spwm_pkg::DUTY_W-1:0];
    if (duty > spwm_pkg::DUTY_W'(hi)) begin
      duty = spwm_pkg::DUTY_W'(hi);
    end else if (duty < spwm_pkg::DUTY_W'(lo)) begin
      duty = spwm_pkg::DUTY_W'(lo);
    end
    sum = $signed({3'b000, half[spwm_pkg::CMP_W-1:1]}) + (spwm_pkg::DUTY_W+1)'(duty);
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed((spwm_pkg::DUTY_W+1)'(18'd65535))) begin
      return '1;
    end
    return sum[spwm_pkg::CMP_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.compare_r <= to_compare(prod_r_r, duty_hi_r, duty_lo_r, half_per_r);
      out_data.compare_s <= to_compare(prod_s_r, duty_hi_r, duty_lo_r, half_per_r);
      out_data.compare_t <= to_compare(prod_t_r, duty_hi_r, duty_lo_r, half_per_r);
    end
  end

  // a stalled pipe keeps its beats in place
  `SPWM_ASSERT_NEXT(a_stall_holds, !en, $stable(rom_valid_r) && $stable(mul_valid_r))
  // a beat leaving the multiplier lands in the output register
  `SPWM_ASSERT_NEXT(a_mul_to_out, mul_valid_r && en, out_valid)
  // input is refused only while a finished beat waits
  `SPWM_ASSERT_NOW(a_ready_rule, !in_ready, out_valid && !out_ready)

endmodule
`default_nettype wire

FILE: sim/three_phase_sine_pwm_reference_top_tb.sv
// self-checking testbench for the three-phase sine pwm compare generator
`default_nettype none
module three_phase_sine_pwm_reference_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // no register sits at these indexes, so a write there must change nothing
  localparam logic [spwm_pkg::CFG_IDX_W-1:0] REG_NONE  = 3'd6;
  localparam logic [spwm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // cycles without any accepted beat or register write before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // drain time before a register write, a little above the pipe latency
  localparam int PIPE_DRAIN = 64;

  typedef struct {
    logic [31:0] timer;
    logic [31:0] period;
    bit          zero_at_reset; // all compares read 0 with reset registers
  } row_t;

  logic                start_clk;
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  spwm_pkg::spwm_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  spwm_pkg::spwm_out_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data;

  // own copy of the register file
  logic [18:0] amp_r, amp_s, amp_t;
  logic signed [15:0] lim_hi, lim_lo;
  logic [15:0] half_per;

  logic signed [15:0] wave [spwm_pkg::SINE_DEPTH];
  spwm_pkg::spwm_out_t compare_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int items_sent;
  int results_seen;
  int cfg_writes;
  int quiet_cycles;

  three_phase_sine_pwm_reference_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // quarter-wave taylor series in q30, rounded to q1.15
  function automatic logic signed [15:0] wave_sample(int k);
    longint unsigned turn, frac, x, term, rnd;
    longint acc;
    turn = (longint'(k) << 32) / spwm_pkg::SINE_DEPTH;
    frac = turn & 64'h3fff_ffff;
    if (turn[30]) begin
      frac = 64'h4000_0000 - frac;
    end
    x    = (frac * 64'd1686629713) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rnd = (longint'(acc) + 64'd16384) >> 15;
    if (rnd > 64'd32767) begin
      rnd = 64'd32767;
    end
    return turn[31] ? -$signed(16'(rnd)) : $signed(16'(rnd));
  endfunction

  // one phase: table lookup, scale, clamp (high first), center, saturate
  function automatic logic [15:0] phase_compare(logic [15:0] ph, logic [18:0] amp);
    longint prod, duty, c;
    prod = longint'(amp) * longint'(wave[ph[15:6]]);
    duty = prod >>> 19;
    if (duty > longint'(lim_hi)) begin
      duty = lim_hi;
    end else if (duty < longint'(lim_lo)) begin
      duty = lim_lo;
    end
    c = longint'(half_per >> 1) + duty;
    if (c < 0) begin
      c = 0;
    end else if (c > 65535) begin
      c = 65535;
    end
    return c[15:0];
  endfunction

  function automatic spwm_pkg::spwm_out_t predict_compares(spwm_pkg::spwm_in_t d);
    longint unsigned num;
    logic [15:0] ph;
    spwm_pkg::spwm_out_t r;
    ph = '0;
    if (d.period_count != 0) begin
      num = {16'b0, d.timer_count, 16'b0};
      ph  = 16'(num / longint'(d.period_count));
    end
    r.compare_r = phase_compare(ph, amp_r);
    r.compare_s = phase_compare(ph + spwm_pkg::OFFSET_240, amp_s);
    r.compare_t = phase_compare(ph + spwm_pkg::OFFSET_120, amp_t);
    return r;
  endfunction

  // one register write; the copy is updated at the accepting edge
  task automatic write_reg(logic [spwm_pkg::CFG_IDX_W-1:0] idx,
                           logic [spwm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      spwm_pkg::REG_AMP_R:    amp_r    = val;
      spwm_pkg::REG_AMP_S:    amp_s    = val;
      spwm_pkg::REG_AMP_T:    amp_t    = val;
      spwm_pkg::REG_DUTY_HI:  lim_hi   = val[15:0];
      spwm_pkg::REG_DUTY_LO:  lim_lo   = val[15:0];
      spwm_pkg::REG_HALF_PER: half_per = val[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(logic [18:0] ar, logic [18:0] as_, logic [18:0] at,
                           logic [15:0] hi, logic [15:0] lo, logic [15:0] hp);
    write_reg(spwm_pkg::REG_AMP_R, ar);
    write_reg(spwm_pkg::REG_AMP_S, as_);
    write_reg(spwm_pkg::REG_AMP_T, at);
    write_reg(spwm_pkg::REG_DUTY_HI, {3'b0, hi});
    write_reg(spwm_pkg::REG_DUTY_LO, {3'b0, lo});
    write_reg(spwm_pkg::REG_HALF_PER, {3'b0, hp});
  endtask

  // valid only drops when the sender decides to idle, never low-then-high in one step
  task automatic send_beat(spwm_pkg::spwm_in_t d, bit use_lit, spwm_pkg::spwm_out_t lit);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compare_q.push_back(use_lit ? lit : predict_compares(d));
    items_sent++;
  endtask

  // sender pauses here until every expected beat is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (compare_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic spwm_pkg::spwm_in_t random_item();
    spwm_pkg::spwm_in_t d;
    int pick;
    pick = $urandom_range(99);
    d.timer_count  = $urandom;
    d.period_count = $urandom;
    if (pick < 8) begin
      // pure noise, timer past the period in about half of the items
    end else if (pick < 14) begin
      d.period_count = '0;
    end else begin
      if (pick < 60) begin
        d.period_count = $urandom_range(4096, 1);
      end
      if (pick < 90) begin
        d.timer_count = $urandom % d.period_count;
      end else begin
        // at or just past the period end, so the phase wraps
        d.timer_count = d.period_count + $urandom_range(3);
      end
    end
    return d;
  endfunction

  function automatic logic [18:0] random_amp();
    case ($urandom_range(3))
      0: return 19'h7ffff;
      1: return '0;
      default: return 19'($urandom_range(524287));
    endcase
  endfunction

  // outputs checked at the edge that accepts them
  always @(posedge clk) begin
    spwm_pkg::spwm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (compare_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat r=%0d s=%0d t=%0d",
                   out_data.compare_r, out_data.compare_s, out_data.compare_t);
        end
      end else begin
        want = compare_q.pop_front();
        if (out_data.compare_r !== want.compare_r ||
            out_data.compare_s !== want.compare_s ||
            out_data.compare_t !== want.compare_t) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch beat %0d: r %0d/%0d s %0d/%0d t %0d/%0d (expected/actual)",
                     results_seen, want.compare_r, out_data.compare_r,
                     want.compare_s, out_data.compare_s,
                     want.compare_t, out_data.compare_t);
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hang detection
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [$];
    spwm_pkg::spwm_in_t d;
    spwm_pkg::spwm_out_t zero;
    int pass;
    rows = '{
      '{32'h0,        32'h0,        1'b1},  // zero period
      '{32'hffffffff, 32'h0,        1'b1},
      '{32'h0,        32'h1,        1'b1},
      '{32'hffffffff, 32'hffffffff, 1'b1},  // timer equals period
      '{32'd1000,     32'd1000,     1'b1},
      '{32'd3000,     32'd1000,     1'b1},  // timer beyond period
      '{32'd250,      32'd1000,     1'b1},
      '{32'd500,      32'd1000,     1'b1},
      '{32'd750,      32'd1000,     1'b1},
      '{32'd1,        32'd3,        1'b1},
      '{32'hffffffff, 32'h1,        1'b1},
      '{32'h7fffffff, 32'hffffffff, 1'b1},
      '{32'h12345678, 32'h89abcdef, 1'b1}
    };
    zero = '0;
    for (int k = 0; k < spwm_pkg::SINE_DEPTH; k++) begin
      wave[k] = wave_sample(k);
    end
    amp_r = '0; amp_s = '0; amp_t = '0;
    lim_hi = 16'sh7fff; lim_lo = -16'sh8000; half_per = '0;
    mismatches = 0; items_sent = 0; results_seen = 0; cfg_writes = 0;
    quiet_cycles = 0;
    send_idle_pct = 38; recv_stall_pct = 64;
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table: reset registers, then full amplitude at the full half period,
    // saturating low, and inverted limits where the high limit is checked first
    for (pass = 0; pass < 4; pass++) begin
      case (pass)
        1: load_regs(19'h7ffff, 19'h7ffff, 19'h7ffff, 16'h7fff, 16'h8000, 16'hffff);
        2: load_regs(19'h7ffff, 19'h40000, 19'h1, 16'h7fff, 16'h8000, 16'h0);
        3: begin
          load_regs(19'h7ffff, 19'h7ffff, 19'h7ffff, 16'hff9c, 16'h0064, 16'h1000);
          write_reg(REG_NONE, 19'h7ffff);  // ignored index
        end
        default: ;
      endcase
      foreach (rows[i]) begin
        d.timer_count  = rows[i].timer;
        d.period_count = rows[i].period;
        send_beat(d, pass == 0 && rows[i].zero_at_reset, zero);
      end
      drain();
    end

    // random part: ten register settings, idling pattern by thirds
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 38; recv_stall_pct = 64;
      end else if (ph < 6) begin
        send_idle_pct = 64; recv_stall_pct = 38;
      end else begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      case (ph)
        0: load_regs(19'h7ffff, 19'h7ffff, 19'h7ffff, 16'h8000, 16'h7fff, 16'h8000);
        1: load_regs(19'h0, 19'h7ffff, 19'h0, 16'h7fff, 16'h8000, 16'hffff);
        default: load_regs(random_amp(), random_amp(), random_amp(),
                           16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      if (ph == 4) begin
        write_reg(REG_SPARE, 19'($urandom));
      end
      for (int n = 0; n < 80; n++) begin
        send_beat(random_item(), 1'b0, zero);
      end
      drain();
    end

    $display("sent %0d input beats, checked %0d result beats, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("covered zero and wrapped periods, saturation, inverted limits, %0d mismatches",
             mismatches);
    if (mismatches == 0 && compare_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
